// ===== rtl/msp_pkg.sv =====
// Package for the multiplexed servo pulse generator.
// Word types, operation and register codes, limits and shared helpers.
// No dependencies.
`default_nettype none

package msp_pkg;

  localparam int CHANNELS = 4;
  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int LINE_W   = 4;

  localparam logic [1:0] OP_TICK      = 2'd0;
  localparam logic [1:0] OP_SET_ANGLE = 2'd1;
  localparam logic [1:0] OP_SET_PULSE = 2'd2;
  localparam logic [1:0] OP_READ      = 2'd3;

  localparam logic [1:0] REG_MIN_PULSE   = 2'd0;
  localparam logic [1:0] REG_MAX_PULSE   = 2'd1;
  localparam logic [1:0] REG_CHANNEL_GAP = 2'd2;
  localparam logic [1:0] REG_FRAME_GAP   = 2'd3;

  localparam logic [7:0]  ANGLE_MAX         = 8'd180;
  localparam logic [7:0]  ANGLE_RESET       = 8'd90;
  localparam logic [11:0] PULSE_RESET       = 12'd1500;
  localparam logic [11:0] MIN_PULSE_RESET   = 12'd1000;
  localparam logic [11:0] MAX_PULSE_RESET   = 12'd2000;
  localparam logic [15:0] CHANNEL_GAP_RESET = 16'd3000;
  localparam logic [15:0] FRAME_GAP_RESET   = 16'd12000;
  localparam logic [15:0] START_DELAY       = 16'd500;

  // floor(x / 180) = floor(floor(x / 4) / 45); 45 via reciprocal, exact for x / 4 < 2^18
  localparam int          RECIP_SHIFT = 24;
  localparam logic [18:0] RECIP_45    = 19'd372828;

  typedef struct packed {
    logic [1:0]  operation;
    logic [2:0]  servo_index;
    logic [7:0]  angle_deg;
    logic [15:0] pulse_width_us;
  } msp_item_t;

  typedef struct packed {
    logic [LINE_W-1:0] servo_lines;
    logic [7:0]        angle_read;
  } msp_result_t;

  typedef struct packed {
    logic load_prod;
    logic load_quot;
  } msp_scale_en_t;

  function automatic logic [7:0] clamp_angle(input logic [7:0] a);
    clamp_angle = (a > ANGLE_MAX) ? ANGLE_MAX : a;
  endfunction

  function automatic logic [11:0] clamp_pulse(input logic [15:0] p,
                                              input logic [11:0] lo,
                                              input logic [11:0] hi);
    logic [15:0] v;
    v = p;
    if (v < {4'd0, lo}) begin
      v = {4'd0, lo};
    end
    if (v > {4'd0, hi}) begin
      v = {4'd0, hi};
    end
    clamp_pulse = v[11:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/msp_scale.sv =====
// Angle to pulse offset: floor(angle * (max - min) / 180) in two multiply stages.
// Depends on msp_pkg.
`default_nettype none

module msp_scale
  import msp_pkg::*;
(
  input  wire logic          clk,
  input  wire msp_scale_en_t en,
  input  wire logic [7:0]    angle_deg,
  input  wire logic [11:0]   min_pulse,
  input  wire logic [11:0]   max_pulse,
  output logic [11:0]        offset
);

  logic [7:0]  angle;
  logic [11:0] span;
  logic [19:0] prod;
  logic [36:0] recip_prod;

  always_comb begin
    angle = clamp_angle(angle_deg);
    span  = (max_pulse >= min_pulse) ? (max_pulse - min_pulse) : 12'd0;
  end

  assign recip_prod = 37'(prod[19:2]) * 37'(RECIP_45);

  always_ff @(posedge clk) begin
    if (en.load_prod) begin
      prod <= 20'(angle) * 20'(span);
    end
    if (en.load_quot) begin
      offset <= recip_prod[RECIP_SHIFT +: 12];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/multiplexed_servo_pulse_generator.sv =====
// Top level of the multiplexed servo pulse generator: item pipeline, channel
// sequencer, stored widths and angles, config registers. Uses msp_pkg, msp_scale.
//
// Takes one word per cycle while item_stall is low and returns one result word
// per item after an input stage that forms angle * span, a stage for the
// divide by 180 via reciprocal multiply, an execute stage that updates the
// sequencer and the per-channel tables, and the output register. Each tick
// word is one microsecond of the servo time base. Config registers are taken
// every cycle (cfg_ready stays high) and must only be written while idle.
`default_nettype none

module multiplexed_servo_pulse_generator
  import msp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire msp_item_t   item,
  output logic             result_valid,
  input  wire logic        result_stall,
  output msp_result_t      result,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic [11:0] min_pulse;
  logic [11:0] max_pulse;
  logic [15:0] channel_gap;
  logic [15:0] frame_gap;

  logic        a_valid;
  msp_item_t   a_item;
  logic        b_valid;
  msp_item_t   b_item;
  logic        c_valid;
  msp_item_t   c_item;
  logic [11:0] offset;

  logic        out_en;
  logic        c_en;
  logic        b_en;
  logic        a_en;
  logic        exec;
  msp_scale_en_t scale_en;

  logic [11:0]         pulse_widths [CHANNELS];
  logic [7:0]          angles [CHANNELS];
  logic [CH_W-1:0]     active_channel;
  logic                pulse_high_phase;
  logic [15:0]         countdown;
  logic [CHANNELS-1:0] line_levels;

  logic [CH_W-1:0]     active_channel_next;
  logic                pulse_high_phase_next;
  logic [15:0]         countdown_next;
  logic [CHANNELS-1:0] line_levels_next;
  logic                id_ok;
  logic [CH_W-1:0]     id;
  logic [12:0]         angle_sum;
  logic [CH_W:0]       ch_inc;
  msp_result_t         result_next;

  assign out_en     = !result_valid || !result_stall;
  assign c_en       = !c_valid || out_en;
  assign b_en       = !b_valid || c_en;
  assign a_en       = !a_valid || b_en;
  assign item_stall = !a_en;
  assign exec       = c_valid && out_en;
  assign cfg_ready  = 1'b1;

  assign scale_en.load_prod = b_en;
  assign scale_en.load_quot = c_en;

  msp_scale u_scale (
    .clk       (clk),
    .en        (scale_en),
    .angle_deg (a_item.angle_deg),
    .min_pulse (min_pulse),
    .max_pulse (max_pulse),
    .offset    (offset)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid      <= 1'b0;
      b_valid      <= 1'b0;
      c_valid      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (a_en) begin
        a_valid <= item_valid;
      end
      if (b_en) begin
        b_valid <= a_valid;
      end
      if (c_en) begin
        c_valid <= b_valid;
      end
      if (out_en) begin
        result_valid <= c_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_en) begin
      a_item <= item;
    end
    if (b_en) begin
      b_item <= a_item;
    end
    if (c_en) begin
      c_item <= b_item;
    end
    if (exec) begin
      result <= result_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_pulse   <= MIN_PULSE_RESET;
      max_pulse   <= MAX_PULSE_RESET;
      channel_gap <= CHANNEL_GAP_RESET;
      frame_gap   <= FRAME_GAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MIN_PULSE:   min_pulse   <= cfg_data[11:0];
        REG_MAX_PULSE:   max_pulse   <= cfg_data[11:0];
        REG_CHANNEL_GAP: channel_gap <= cfg_data;
        REG_FRAME_GAP:   frame_gap   <= cfg_data;
        default: ;
      endcase
    end
  end

  // execute stage
  always_comb begin
    id_ok     = {1'b0, c_item.servo_index} < 4'(CHANNELS);
    id        = c_item.servo_index[CH_W-1:0];
    angle_sum = {1'b0, min_pulse} + {1'b0, offset};
    ch_inc    = {1'b0, active_channel} + (CH_W+1)'(1);

    active_channel_next   = active_channel;
    pulse_high_phase_next = pulse_high_phase;
    countdown_next        = countdown;
    line_levels_next      = line_levels;

    if (c_item.operation == OP_TICK) begin
      if (countdown <= 16'd1) begin
        if (!pulse_high_phase) begin
          line_levels_next[active_channel] = 1'b1;
          countdown_next                   = {4'd0, pulse_widths[active_channel]};
          pulse_high_phase_next            = 1'b1;
        end else begin
          line_levels_next[active_channel] = 1'b0;
          if (ch_inc >= (CH_W+1)'(CHANNELS)) begin
            active_channel_next = '0;
            countdown_next      = frame_gap;
          end else begin
            active_channel_next = ch_inc[CH_W-1:0];
            countdown_next      = channel_gap;
          end
          pulse_high_phase_next = 1'b0;
        end
      end else begin
        countdown_next = countdown - 16'd1;
      end
    end

    result_next.servo_lines = '0;
    for (int k = 0; k < LINE_W; k++) begin
      if (k < CHANNELS) begin
        result_next.servo_lines[k] = line_levels_next[k];
      end
    end
    result_next.angle_read = (c_item.operation == OP_READ && id_ok) ? angles[id] : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_channel   <= '0;
      pulse_high_phase <= 1'b0;
      countdown        <= START_DELAY;
      line_levels      <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        pulse_widths[i] <= PULSE_RESET;
        angles[i]       <= ANGLE_RESET;
      end
    end else if (exec) begin
      active_channel   <= active_channel_next;
      pulse_high_phase <= pulse_high_phase_next;
      countdown        <= countdown_next;
      line_levels      <= line_levels_next;
      if (id_ok) begin
        case (c_item.operation)
          OP_SET_ANGLE: begin
            pulse_widths[id] <= clamp_pulse(16'(angle_sum), min_pulse, max_pulse);
            angles[id]       <= clamp_angle(c_item.angle_deg);
          end
          OP_SET_PULSE: begin
            pulse_widths[id] <= clamp_pulse(c_item.pulse_width_us, min_pulse, max_pulse);
          end
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/msp_checker.sv =====
// Port-level checks for the multiplexed servo pulse generator, bound to the top.
// Depends on msp_pkg.
`default_nettype none

module msp_checker
  import msp_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        result_valid,
  input wire logic        result_stall,
  input wire msp_result_t result
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result word changed");

  a_one_line: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $onehot0(result.servo_lines))
    else $error("more than one servo line high");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.angle_read <= ANGLE_MAX)
    else $error("read angle above limit");

endmodule

bind multiplexed_servo_pulse_generator msp_checker u_msp_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

`default_nettype wire

// ===== test/tb_multiplexed_servo_pulse_generator.sv =====
// Testbench for multiplexed_servo_pulse_generator: directed and random item words
// checked against a cycle-free prediction of the channel sequencer and tables.
// Depends on msp_pkg and the block's RTL only.
module tb_multiplexed_servo_pulse_generator;
  import msp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  msp_item_t   item = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  msp_result_t result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  multiplexed_servo_pulse_generator uut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predicted state of the sequencer, tables and registers
  logic [11:0]       width_tab [CHANNELS];
  logic [7:0]        angle_tab [CHANNELS];
  int                cur_chan = 0;
  bit                in_pulse = 1'b0;
  logic [15:0]       us_left = START_DELAY;
  logic [LINE_W-1:0] line_mask = '0;
  logic [11:0]       lim_lo = MIN_PULSE_RESET;
  logic [11:0]       lim_hi = MAX_PULSE_RESET;
  logic [15:0]       gap_chan = CHANNEL_GAP_RESET;
  logic [15:0]       gap_frame = FRAME_GAP_RESET;
  int                events_fired = 0;

  msp_result_t pending_results [$];
  msp_result_t want_word;
  int          mismatches = 0;
  int          results_seen = 0;
  int          cycle_count = 0;
  bit          idling = 1'b1;

  initial begin
    for (int i = 0; i < CHANNELS; i++) begin
      width_tab[i] = PULSE_RESET;
      angle_tab[i] = ANGLE_RESET;
    end
  end

  function automatic logic [11:0] limit_width(input int unsigned p);
    if (p < 32'(lim_lo)) p = 32'(lim_lo);
    if (p > 32'(lim_hi)) p = 32'(lim_hi);
    return p[11:0];
  endfunction

  function automatic void sequence_event();
    events_fired++;
    if (!in_pulse) begin
      if (cur_chan < LINE_W) line_mask[cur_chan] = 1'b1;
      us_left  = {4'd0, width_tab[cur_chan]};
      in_pulse = 1'b1;
    end else begin
      if (cur_chan < LINE_W) line_mask[cur_chan] = 1'b0;
      if (cur_chan == CHANNELS - 1) begin
        cur_chan = 0;
        us_left  = gap_frame;
      end else begin
        cur_chan++;
        us_left = gap_chan;
      end
      in_pulse = 1'b0;
    end
  endfunction

  function automatic void servo_step(input msp_item_t w);
    msp_result_t r;
    int unsigned ang;
    int unsigned span;
    r.angle_read = '0;
    case (w.operation)
      OP_TICK: begin
        if (us_left <= 16'd1) sequence_event();
        else us_left--;
      end
      OP_SET_ANGLE: begin
        if (w.servo_index < 3'(CHANNELS)) begin
          ang  = 32'((w.angle_deg > ANGLE_MAX) ? ANGLE_MAX : w.angle_deg);
          span = (lim_hi >= lim_lo) ? 32'(lim_hi - lim_lo) : 0;
          width_tab[w.servo_index] = limit_width(32'(lim_lo) + ang * span / 180);
          angle_tab[w.servo_index] = ang[7:0];
        end
      end
      OP_SET_PULSE: begin
        if (w.servo_index < 3'(CHANNELS))
          width_tab[w.servo_index] = limit_width(32'(w.pulse_width_us));
      end
      default: begin
        if (w.servo_index < 3'(CHANNELS)) r.angle_read = angle_tab[w.servo_index];
      end
    endcase
    r.servo_lines = line_mask;
    pending_results.push_back(r);
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("ERROR result %0d: %s is %0d, expected %0d", results_seen, what, got, want);
    mismatches++;
  endtask

  task automatic send_word(input logic [1:0] op, input logic [2:0] idx,
                           input logic [7:0] ang, input logic [15:0] pw);
    msp_item_t w;
    w.operation      = op;
    w.servo_index    = idx;
    w.angle_deg      = ang;
    w.pulse_width_us = pw;
    @(negedge clk);
    while (idling && $urandom_range(99) < 10) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item       <= w;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    servo_step(w);
  endtask

  task automatic send_tick();
    send_word(OP_TICK, 3'($urandom_range(7)), 8'($urandom_range(255)),
              16'($urandom_range(65535)));
  endtask

  task automatic drain_results();
    @(negedge clk);
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_MIN_PULSE:   lim_lo = val[11:0];
      REG_MAX_PULSE:   lim_hi = val[11:0];
      REG_CHANNEL_GAP: gap_chan = val;
      default:         gap_frame = val;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [2:0] pick_index();
    if ($urandom_range(4) == 0) return 3'($urandom_range(7, 4));
    return 3'($urandom_range(3));
  endfunction

  function automatic logic [15:0] pick_width();
    int unsigned r;
    r = $urandom_range(3);
    if (r < 2) return 16'($urandom_range(60));
    if (r == 2) return 16'($urandom_range(4095));
    return 16'($urandom_range(65535));
  endfunction

  // reset contents, bad ids
  task automatic test_reset_reads();
    for (int i = 0; i < 8; i++) send_word(OP_READ, 3'(i), 8'd0, 16'd0);
    send_word(OP_SET_ANGLE, 3'd5, 8'd10, 16'd0);
    send_word(OP_SET_PULSE, 3'd7, 8'd0, 16'd1200);
    send_word(OP_READ, 3'd5, 8'd0, 16'd0);
  endtask

  // 500 us start delay, zero-width pulse, shortest gaps, wrap into the next frame
  task automatic test_start_delay();
    drain_results();
    write_reg(REG_MIN_PULSE, 16'd0);
    write_reg(REG_MAX_PULSE, 16'd20);
    write_reg(REG_CHANNEL_GAP, 16'd1);
    write_reg(REG_FRAME_GAP, 16'd1);
    send_word(OP_SET_PULSE, 3'd0, 8'd0, 16'd0);
    send_word(OP_SET_PULSE, 3'd1, 8'd0, 16'hFFFF);
    send_word(OP_SET_ANGLE, 3'd2, 8'd255, 16'd0);
    send_word(OP_SET_ANGLE, 3'd3, 8'd0, 16'd0);
    send_word(OP_READ, 3'd2, 8'd0, 16'd0);
    send_word(OP_READ, 3'd3, 8'd0, 16'd0);
    idling = 1'b0;
    while (events_fired < 2 * CHANNELS + 1) send_tick();
    idling = 1'b1;
  endtask

  // limit extremes, inverted limits, angle clamp
  task automatic test_pulse_limits();
    drain_results();
    write_reg(REG_MIN_PULSE, 16'd0);
    write_reg(REG_MAX_PULSE, 16'd4095);
    send_word(OP_SET_ANGLE, 3'd0, 8'd180, 16'd0);
    send_word(OP_SET_ANGLE, 3'd1, 8'd255, 16'd0);
    send_word(OP_SET_ANGLE, 3'd2, 8'd0, 16'd0);
    send_word(OP_SET_ANGLE, 3'd3, 8'd1, 16'd0);
    send_word(OP_READ, 3'd1, 8'd0, 16'd0);
    drain_results();
    write_reg(REG_MIN_PULSE, 16'd4095);
    send_word(OP_SET_PULSE, 3'd2, 8'd0, 16'd0);
    send_word(OP_SET_ANGLE, 3'd3, 8'd90, 16'd0);
    drain_results();
    write_reg(REG_MAX_PULSE, 16'd0);
    send_word(OP_SET_ANGLE, 3'd0, 8'd45, 16'd0);
    send_word(OP_SET_PULSE, 3'd1, 8'd0, 16'hFFFF);
    drain_results();
    write_reg(REG_MIN_PULSE, 16'd0);
    send_word(OP_SET_PULSE, 3'd3, 8'd0, 16'd12);
    for (int i = 0; i < CHANNELS; i++) send_word(OP_READ, 3'(i), 8'd0, 16'd0);
    drain_results();
    write_reg(REG_MAX_PULSE, 16'd20);
    for (int i = 0; i < CHANNELS; i++) send_word(OP_SET_PULSE, 3'(i), 8'd0, 16'(3 * i + 2));
  endtask

  // longest gaps: load a 65535 us gap and check the first part of it
  task automatic test_long_gap();
    drain_results();
    write_reg(REG_CHANNEL_GAP, 16'hFFFF);
    write_reg(REG_FRAME_GAP, 16'hFFFF);
    while (in_pulse || us_left != 16'hFFFF) send_tick();
    repeat (16) send_tick();
  endtask

  task automatic test_random();
    bit          wide;
    int unsigned r;
    logic [1:0]  op;
    for (int phase = 0; phase < 6; phase++) begin
      drain_results();
      wide   = (phase == 2);
      idling = (phase != 4);
      if (wide) begin
        // no ticks here: widths may reach 4095
        write_reg(REG_MIN_PULSE, $urandom_range(1) ? 16'd0 : 16'($urandom_range(4095)));
        write_reg(REG_MAX_PULSE, $urandom_range(1) ? 16'd4095 : 16'($urandom_range(4095)));
      end else begin
        write_reg(REG_MIN_PULSE, 16'($urandom_range(12)));
        write_reg(REG_MAX_PULSE, 16'($urandom_range(40)));
        write_reg(REG_CHANNEL_GAP, 16'($urandom_range(12, 1)));
        write_reg(REG_FRAME_GAP, 16'($urandom_range(30, 1)));
        if (phase == 3) begin
          for (int i = 0; i < CHANNELS; i++)
            send_word(OP_SET_PULSE, 3'(i), 8'd0, 16'($urandom_range(40)));
        end
      end
      for (int n = 0; n < 20; n++) begin
        r = $urandom_range(99);
        if (wide) op = (r < 34) ? OP_SET_ANGLE : (r < 67) ? OP_SET_PULSE : OP_READ;
        else op = (r < 62) ? OP_TICK : (r < 75) ? OP_SET_ANGLE : (r < 88) ? OP_SET_PULSE : OP_READ;
        send_word(op, pick_index(), 8'($urandom_range(255)), pick_width());
      end
    end
    idling = 1'b1;
  endtask

  always @(negedge clk) begin
    result_stall <= idling && ($urandom_range(99) < 10);
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word, servo_lines", 32'(result.servo_lines), 0);
      end else begin
        want_word = pending_results.pop_front();
        if (result.servo_lines !== want_word.servo_lines)
          report_mismatch("servo_lines", 32'(result.servo_lines),
                          32'(want_word.servo_lines));
        if (result.angle_read !== want_word.angle_read)
          report_mismatch("angle_read", 32'(result.angle_read), 32'(want_word.angle_read));
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("ERROR timeout with %0d words outstanding", pending_results.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_reads();
    test_start_delay();
    test_pulse_limits();
    test_random();
    test_long_gap();
    drain_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== multiplexed_servo_pulse_generator.f =====
rtl/msp_pkg.sv
rtl/msp_scale.sv
rtl/multiplexed_servo_pulse_generator.sv
rtl/msp_checker.sv
test/tb_multiplexed_servo_pulse_generator.sv
